>>> design/frm_pkg.sv
// Shared constants, types and state codes for the frame rate meter and limiter.
`timescale 1ns / 1ps
`default_nettype none
package frm_pkg;

	// Ring of recent frame periods
	localparam int AVG_DEPTH = 10;
	localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int CNT_W     = $clog2(AVG_DEPTH + 1);
	localparam int PER_W     = 16;
	localparam int SUM_W     = $clog2(AVG_DEPTH * 65535 + 1);

	// Field widths
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 10;
	localparam int FPS_W   = 22;
	localparam int DELAY_W = 10;
	localparam int RATIO_W = 16;

	// Rate numerator: 1000 ms/s in Q.8
	localparam int FPS_SCALE = 256000;
	localparam int NUM_W     = $clog2(FPS_SCALE * AVG_DEPTH + 1);
	localparam int FPS_MAX   = (1 << FPS_W) - 1;
	localparam int BUDGET_NUM = 1000;

	// Shared divider: ratio dividend is an 18-bit period shifted up by 8
	localparam int RAT_DVD_W = 26;
	localparam int DIV_W     = (NUM_W > RAT_DVD_W) ? NUM_W : RAT_DVD_W;
	localparam int DSR_W     = (SUM_W > CFG_W) ? SUM_W : CFG_W;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// APB register map
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_MAX_FPS = 1'b0;
	localparam logic REG_DESIRED = 1'b1;
	localparam logic [CFG_W-1:0] MAX_FPS_RST = CFG_W'(60);
	localparam logic [CFG_W-1:0] DESIRED_RST = CFG_W'(16);

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WRITE,
		S_SUM,
		S_FPS_GO,
		S_FPS_WAIT,
		S_RAT_GO,
		S_RAT_WAIT,
		S_BUD_GO,
		S_BUD_WAIT,
		S_DONE
	} seq_state_t;

endpackage
`default_nettype wire

>>> design/frm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module frm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 10
) (
	input  wire logic                                         clk,
	input  wire logic                                         we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                             wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> design/frm_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module frm_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire frm_pkg::div_req_t req,
	output frm_pkg::div_rsp_t      rsp
);
	import frm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DSR_W-1:0]     rem_q;
	logic [DSR_W-1:0]     dsr_q;
	logic [DSR_W:0]       rem_sh;
	logic [DSR_W+1:0]     diff;

	// Shift in the next dividend bit and try the subtract
	assign rem_sh = {rem_q, quo_q[DIV_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[DSR_W+1]) begin
				rem_q <= diff[DSR_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DSR_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

>>> design/frm_seq.sv
// Sequencer and datapath: period ring update, running sum, divider steps, result word.
`timescale 1ns / 1ps
`default_nettype none
module frm_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [frm_pkg::TIME_W-1:0]    start_time,
	input  wire logic [frm_pkg::TIME_W-1:0]    end_time,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [frm_pkg::FPS_W-1:0]     fps_q8,
	output logic      [frm_pkg::DELAY_W-1:0]   delay_ms,
	output logic      [frm_pkg::RATIO_W-1:0]   delta_ratio_q8,
	input  wire logic [frm_pkg::CFG_W-1:0]     max_fps,
	input  wire logic [frm_pkg::CFG_W-1:0]     desired_frame_ms,
	output frm_pkg::div_req_t                  div_req,
	input  wire frm_pkg::div_rsp_t             div_rsp
);
	import frm_pkg::*;

	seq_state_t state_q, state_d;

	logic [TIME_W-1:0]  prev_start_q;
	logic [TIME_W-1:0]  start_q;
	logic [TIME_W-1:0]  end_q;
	logic [TIME_W-1:0]  period_q;
	logic [TIME_W-1:0]  work_q;
	logic [SLOT_W-1:0]  write_slot_q;
	logic [CNT_W-1:0]   fill_count_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic               rd_pend_q;
	logic [SUM_W-1:0]   sum_q;
	logic [FPS_W-1:0]   fps_res_q;
	logic [RATIO_W-1:0] ratio_res_q;
	logic [DELAY_W-1:0] delay_res_q;
	logic               out_valid_q;
	logic [FPS_W-1:0]   out_fps_q;
	logic [DELAY_W-1:0] out_delay_q;
	logic [RATIO_W-1:0] out_ratio_q;

	logic               accept;
	logic               ram_we;
	logic [PER_W-1:0]   ram_wdata;
	logic [PER_W-1:0]   ram_rdata;
	logic               sum_issue;
	logic               fps_zero;
	logic               rat_sat;
	logic               bud_off;
	logic               out_free;
	logic               out_load;
	logic [DELAY_W-1:0] budget;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign budget   = div_rsp.quotient[DELAY_W-1:0];

	frm_ram #(
		.WIDTH(PER_W),
		.DEPTH(AVG_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(write_slot_q),
		.wdata(ram_wdata),
		.raddr(rd_idx_q[SLOT_W-1:0]),
		.rdata(ram_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (in_valid) state_d = S_WRITE;
			S_WRITE:    state_d = S_SUM;
			S_SUM:      if (!sum_issue && !rd_pend_q) state_d = S_FPS_GO;
			S_FPS_GO:   state_d = fps_zero ? S_RAT_GO : S_FPS_WAIT;
			S_FPS_WAIT: if (div_rsp.done) state_d = S_RAT_GO;
			S_RAT_GO:   state_d = rat_sat ? S_BUD_GO : S_RAT_WAIT;
			S_RAT_WAIT: if (div_rsp.done) state_d = S_BUD_GO;
			S_BUD_GO:   state_d = bud_off ? S_DONE : S_BUD_WAIT;
			S_BUD_WAIT: if (div_rsp.done) state_d = S_DONE;
			S_DONE:     if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_stall         = 1'b1;
		ram_we           = 1'b0;
		ram_wdata        = (period_q[TIME_W-1:PER_W] != '0) ? '1 : period_q[PER_W-1:0];
		sum_issue        = 1'b0;
		fps_zero         = (sum_q == '0);
		rat_sat          = (period_q >= {14'b0, desired_frame_ms, 8'h00});
		bud_off          = (max_fps == '0);
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = DIV_W'(fill_count_q) * DIV_W'(FPS_SCALE);
		div_req.divisor  = DSR_W'(sum_q);
		case (state_q)
			S_IDLE:   in_stall = 1'b0;
			S_WRITE:  ram_we = 1'b1;
			S_SUM:    sum_issue = (rd_idx_q != fill_count_q);
			S_FPS_GO: div_req.start = !fps_zero;
			S_RAT_GO: begin
				div_req.start    = !rat_sat;
				div_req.dividend = DIV_W'({period_q[17:0], 8'h00});
				div_req.divisor  = DSR_W'(desired_frame_ms);
			end
			S_BUD_GO: begin
				div_req.start    = !bud_off;
				div_req.dividend = DIV_W'(BUDGET_NUM);
				div_req.divisor  = DSR_W'(max_fps);
			end
			S_DONE:   out_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prev_start_q <= '0;
			write_slot_q <= '0;
			fill_count_q <= '0;
			rd_pend_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				prev_start_q <= start_time;
			end
			if (ram_we) begin
				write_slot_q <= (write_slot_q == SLOT_W'(AVG_DEPTH - 1)) ?
					'0 : write_slot_q + SLOT_W'(1);
				if (fill_count_q != CNT_W'(AVG_DEPTH)) begin
					fill_count_q <= fill_count_q + CNT_W'(1);
				end
			end
			rd_pend_q <= sum_issue;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_q  <= start_time;
			end_q    <= end_time;
			period_q <= start_time - prev_start_q;
		end
		if (ram_we) begin
			work_q   <= end_q - start_q;
			rd_idx_q <= '0;
			sum_q    <= '0;
		end
		if (sum_issue) begin
			rd_idx_q <= rd_idx_q + CNT_W'(1);
		end
		// Read data arrives in the cycle after its address
		if (rd_pend_q) begin
			sum_q <= sum_q + SUM_W'(ram_rdata);
		end
		if (state_q == S_FPS_GO && fps_zero) begin
			fps_res_q <= '0;
		end
		if (state_q == S_FPS_WAIT && div_rsp.done) begin
			fps_res_q <= (div_rsp.quotient > DIV_W'(FPS_MAX)) ?
				'1 : div_rsp.quotient[FPS_W-1:0];
		end
		if (state_q == S_RAT_GO && rat_sat) begin
			ratio_res_q <= '1;
		end
		if (state_q == S_RAT_WAIT && div_rsp.done) begin
			ratio_res_q <= div_rsp.quotient[RATIO_W-1:0];
		end
		if (state_q == S_BUD_GO && bud_off) begin
			delay_res_q <= '0;
		end
		if (state_q == S_BUD_WAIT && div_rsp.done) begin
			delay_res_q <= ({22'b0, budget} > work_q) ?
				budget - work_q[DELAY_W-1:0] : '0;
		end
		if (out_load) begin
			out_fps_q   <= fps_res_q;
			out_delay_q <= delay_res_q;
			out_ratio_q <= ratio_res_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign fps_q8         = out_fps_q;
	assign delay_ms       = out_delay_q;
	assign delta_ratio_q8 = out_ratio_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count_q <= CNT_W'(AVG_DEPTH))
		else $error("fill count beyond ring depth");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		write_slot_q < SLOT_W'(AVG_DEPTH))
		else $error("write slot beyond ring depth");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_FPS_WAIT || state_q == S_RAT_WAIT ||
			state_q == S_BUD_WAIT))
		else $error("divider finished outside a wait state");

	a_accept_write: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_WRITE))
		else $error("accepted word did not start a ring write");

	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (state_q == S_DONE && !(out_valid_q && out_stall)))
		else $error("result loaded over a held word");

endmodule
`default_nettype wire

>>> design/frame_rate_meter_limiter.sv
// Top level: APB configuration registers, sequencer and shared divider.
`timescale 1ns / 1ps
`default_nettype none
// Frame rate meter and limiter. Each input word is one frame (start and end
// millisecond ticks); each produces one result word with the averaged rate over
// the last ten frame periods (fps_q8, Q.8), the frame period over the desired
// period (delta_ratio_q8, Q8.8, saturated) and the delay that keeps the rate
// under max_fps (delay_ms). One frame is in flight at a time: in_stall is high
// from acceptance until the result is handed to the output register. That time
// is set by the 26-step radix-2 divider, which is shared by the rate, ratio and
// budget divisions, and by reading the period ring one entry a cycle; a division
// whose result is fixed by its operands is skipped.
// A finished word waits in the output register while the next frame is taken.
// Registers: max_fps at 0x0 (reset 60), desired_frame_ms at 0x4 (reset 16).
module frame_rate_meter_limiter (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [frm_pkg::TIME_W-1:0]   start_time,
	input  wire logic [frm_pkg::TIME_W-1:0]   end_time,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [frm_pkg::FPS_W-1:0]    fps_q8,
	output logic      [frm_pkg::DELAY_W-1:0]  delay_ms,
	output logic      [frm_pkg::RATIO_W-1:0]  delta_ratio_q8,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [frm_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [frm_pkg::PDATA_W-1:0]  pwdata,
	output logic      [frm_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready
);
	import frm_pkg::*;

	logic [CFG_W-1:0] max_fps_q;
	logic [CFG_W-1:0] desired_q;
	logic             cfg_wr;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fps_q <= MAX_FPS_RST;
			desired_q <= DESIRED_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MAX_FPS: max_fps_q <= pwdata[CFG_W-1:0];
				REG_DESIRED: desired_q <= pwdata[CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_FPS: prdata = PDATA_W'(max_fps_q);
			REG_DESIRED: prdata = PDATA_W'(desired_q);
			default:     prdata = '0;
		endcase
	end

	frm_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.start_time      (start_time),
		.end_time        (end_time),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.fps_q8          (fps_q8),
		.delay_ms        (delay_ms),
		.delta_ratio_q8  (delta_ratio_q8),
		.max_fps         (max_fps_q),
		.desired_frame_ms(desired_q),
		.div_req         (div_req),
		.div_rsp         (div_rsp)
	);

	frm_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

endmodule
`default_nettype wire
